### rtl/hpid_pkg.sv
// Shared types, constants and configuration register codes for the heading PID drive.
package hpid_pkg;

    localparam int HEAD_W     = 13;
    localparam int FULL_TURN  = 5760;
    localparam int HALF_TURN  = 2880;
    localparam int DRIVE_MAX  = 100;
    localparam int FRAC_BITS  = 12;
    localparam int DRIVE_FULL = DRIVE_MAX << FRAC_BITS;

    localparam int ERR_W    = 13;
    localparam int DERIV_W  = 14;
    localparam int INTEG_W  = 21;
    localparam int ISUM_W   = 22;
    localparam int PTERM_W  = 29;
    localparam int DTERM_W  = 30;
    localparam int ITERM_W  = 37;
    localparam int SUM_W    = 38;
    localparam int CMD_W    = SUM_W - FRAC_BITS;
    localparam int DRIVE_W  = 8;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 20;

    localparam logic [15:0] GAIN_P_RESET       = 16'd256;
    localparam logic [15:0] GAIN_I_RESET       = 16'd16;
    localparam logic [15:0] GAIN_D_RESET       = 16'd0;
    localparam logic [19:0] INTEG_LIMIT_RESET  = 20'd16000;
    localparam logic [11:0] STABLE_LIMIT_RESET = 12'd160;
    localparam logic [15:0] WINDOW_MS_RESET    = 16'd5000;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_GAIN_P       = 3'd0,
        CFG_GAIN_I       = 3'd1,
        CFG_GAIN_D       = 3'd2,
        CFG_INTEG_LIMIT  = 3'd3,
        CFG_STABLE_LIMIT = 3'd4,
        CFG_WINDOW_MS    = 3'd5
    } cfg_index_t;

    typedef enum logic {
        KIND_TICK   = 1'b0,
        KIND_TARGET = 1'b1
    } item_kind_t;

    typedef struct packed {
        logic [15:0] gain_p;
        logic [15:0] gain_i;
        logic [15:0] gain_d;
        logic [19:0] integ_limit;
        logic [11:0] stable_limit;
        logic [15:0] window_ms;
    } cfg_t;

    typedef struct packed {
        item_kind_t        kind;
        logic [HEAD_W-1:0] measured;
        logic [HEAD_W-1:0] target;
        logic [31:0]       uptime;
    } item_t;

    typedef struct packed {
        logic signed [PTERM_W-1:0] pterm;
        logic signed [DERIV_W-1:0] deriv;
        logic signed [INTEG_W-1:0] integ;
        logic                      stable;
    } track_t;

    typedef struct packed {
        logic signed [PTERM_W-1:0] pterm;
        logic signed [DTERM_W-1:0] dterm;
        logic signed [ITERM_W-1:0] iterm;
        logic                      stable;
    } prod_t;

endpackage

### rtl/hpid_cfg.sv
// Configuration register file of the heading PID drive.
module hpid_cfg
    import hpid_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output cfg_t                   cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain_p       <= GAIN_P_RESET;
            cfg_reg.gain_i       <= GAIN_I_RESET;
            cfg_reg.gain_d       <= GAIN_D_RESET;
            cfg_reg.integ_limit  <= INTEG_LIMIT_RESET;
            cfg_reg.stable_limit <= STABLE_LIMIT_RESET;
            cfg_reg.window_ms    <= WINDOW_MS_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_GAIN_P:       cfg_reg.gain_p       <= cfg_data[15:0];
                CFG_GAIN_I:       cfg_reg.gain_i       <= cfg_data[15:0];
                CFG_GAIN_D:       cfg_reg.gain_d       <= cfg_data[15:0];
                CFG_INTEG_LIMIT:  cfg_reg.integ_limit  <= cfg_data[19:0];
                CFG_STABLE_LIMIT: cfg_reg.stable_limit <= cfg_data[11:0];
                CFG_WINDOW_MS:    cfg_reg.window_ms    <= cfg_data[15:0];
                default:          ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

### rtl/hpid_track.sv
// Error wrap, controller state update, proportional product and stability window.
module hpid_track
    import hpid_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  cfg_t   cfg,
    input  item_t  item,
    input  logic   item_valid,
    input  logic   advance,
    output track_t result,
    output logic   result_valid
);

    logic [HEAD_W-1:0]         wanted_reg;
    logic                      first_pass_reg;
    logic signed [ERR_W-1:0]   last_error_reg;
    logic signed [INTEG_W-1:0] integ_reg;
    logic [31:0]               window_start_reg;
    track_t                    result_reg;
    logic                      result_valid_reg;

    logic                      consume;
    logic                      is_tick;
    logic [14:0]               shifted;
    logic [HEAD_W-1:0]         wrapped;
    logic signed [ERR_W-1:0]   err;
    logic [11:0]               abs_err;
    logic signed [DERIV_W-1:0] deriv_raw;
    logic signed [ISUM_W-1:0]  isum;
    logic signed [ISUM_W-1:0]  lim_pos;
    logic signed [ISUM_W-1:0]  lim_neg;
    logic signed [INTEG_W-1:0] integ_clamped;
    logic signed [PTERM_W+1:0] err_wide;
    logic signed [PTERM_W+1:0] gain_wide;
    logic signed [PTERM_W+1:0] prod_wide;
    logic signed [PTERM_W-1:0] pterm;
    logic signed [PTERM_W-1:0] full_pos;
    logic signed [PTERM_W-1:0] full_neg;
    logic                      full_drive;
    logic signed [DERIV_W-1:0] deriv_next;
    logic signed [INTEG_W-1:0] integ_next;
    logic [31:0]               window_tmp;
    logic [31:0]               elapsed;
    logic                      stable_next;
    logic [31:0]               window_next;

    assign consume = item_valid && advance;
    assign is_tick = (item.kind == KIND_TICK);

    // Bias the difference by two turns so it stays positive, then take it modulo one turn.
    always_comb
    begin
        shifted = 15'(wanted_reg) + 15'(2 * FULL_TURN) - 15'(item.measured);
        if (shifted >= 15'(3 * FULL_TURN))
            wrapped = 13'(shifted - 15'(3 * FULL_TURN));
        else if (shifted >= 15'(2 * FULL_TURN))
            wrapped = 13'(shifted - 15'(2 * FULL_TURN));
        else if (shifted >= 15'(FULL_TURN))
            wrapped = 13'(shifted - 15'(FULL_TURN));
        else
            wrapped = 13'(shifted);

        if (wrapped >= 13'(HALF_TURN))
            err = $signed(wrapped - 13'(FULL_TURN));
        else
            err = $signed(wrapped);

        abs_err = (err < 0) ? 12'(-err) : 12'(err);
    end

    always_comb
    begin
        if (first_pass_reg)
        begin
            deriv_raw = '0;
            isum      = 22'(err);
        end
        else
        begin
            deriv_raw = 14'(err) - 14'(last_error_reg);
            isum      = 22'(integ_reg) + 22'(err);
        end

        lim_pos = $signed({2'b00, cfg.integ_limit});
        lim_neg = -lim_pos;
        if (isum > lim_pos)
            integ_clamped = 21'(lim_pos);
        else if (isum < lim_neg)
            integ_clamped = 21'(lim_neg);
        else
            integ_clamped = 21'(isum);
    end

    always_comb
    begin
        err_wide   = 31'(err);
        gain_wide  = $signed({15'b0, cfg.gain_p});
        prod_wide  = err_wide * gain_wide;
        pterm      = 29'(prod_wide);
        full_pos   = 29'(DRIVE_FULL);
        full_neg   = -full_pos;
        full_drive = (pterm >= full_pos) || (pterm <= full_neg);

        // At full proportional drive the integral and derivative are dropped.
        deriv_next = full_drive ? '0 : deriv_raw;
        integ_next = full_drive ? '0 : integ_clamped;
    end

    always_comb
    begin
        window_tmp  = (abs_err > cfg.stable_limit) ? item.uptime : window_start_reg;
        elapsed     = item.uptime - window_tmp;
        stable_next = (elapsed > {16'b0, cfg.window_ms});
        window_next = stable_next ? item.uptime : window_tmp;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wanted_reg       <= '0;
            first_pass_reg   <= 1'b1;
            last_error_reg   <= '0;
            integ_reg        <= '0;
            window_start_reg <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
                result_valid_reg <= item_valid && is_tick;
            if (consume)
            begin
                first_pass_reg <= 1'b0;
                if (is_tick)
                begin
                    last_error_reg   <= err;
                    integ_reg        <= integ_next;
                    window_start_reg <= window_next;
                end
                else
                begin
                    wanted_reg     <= item.target;
                    last_error_reg <= '0;
                    integ_reg      <= '0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (consume && is_tick)
        begin
            result_reg.pterm  <= pterm;
            result_reg.deriv  <= deriv_next;
            result_reg.integ  <= integ_next;
            result_reg.stable <= stable_next;
        end
    end

    assign result       = result_reg;
    assign result_valid = result_valid_reg;

    a_full_drive_clears_integral: assert property (
        @(posedge clk) disable iff (!rst_n)
        (consume && is_tick && full_drive) |=> (integ_reg == '0)
    ) else $error("integral kept after a full-drive tick");

endmodule

### rtl/hpid_mult.sv
// Derivative and integral gain products, one register stage.
module hpid_mult
    import hpid_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  cfg_t   cfg,
    input  track_t track,
    input  logic   track_valid,
    input  logic   advance,
    output prod_t  prod,
    output logic   prod_valid
);

    prod_t prod_reg;
    logic  prod_valid_reg;

    logic signed [DTERM_W-1:0] deriv_wide;
    logic signed [DTERM_W-1:0] gain_d_wide;
    logic signed [ITERM_W-1:0] integ_wide;
    logic signed [ITERM_W-1:0] gain_i_wide;

    always_comb
    begin
        deriv_wide  = 30'(track.deriv);
        gain_d_wide = $signed({14'b0, cfg.gain_d});
        integ_wide  = 37'(track.integ);
        gain_i_wide = $signed({21'b0, cfg.gain_i});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            prod_valid_reg <= 1'b0;
        else if (advance)
            prod_valid_reg <= track_valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance && track_valid)
        begin
            prod_reg.pterm  <= track.pterm;
            prod_reg.dterm  <= deriv_wide * gain_d_wide;
            prod_reg.iterm  <= integ_wide * gain_i_wide;
            prod_reg.stable <= track.stable;
        end
    end

    assign prod       = prod_reg;
    assign prod_valid = prod_valid_reg;

endmodule

### rtl/hpid_drive.sv
// Command sum, fixed-point scaling, drive clamp and the output register.
module hpid_drive
    import hpid_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  prod_t                     prod,
    input  logic                      prod_valid,
    input  logic                      advance,
    output logic signed [DRIVE_W-1:0] bow_drive,
    output logic signed [DRIVE_W-1:0] stern_drive,
    output logic                      heading_stable,
    output logic                      out_valid
);

    logic signed [DRIVE_W-1:0] bow_reg;
    logic signed [DRIVE_W-1:0] stern_reg;
    logic                      stable_reg;
    logic                      out_valid_reg;

    logic signed [SUM_W-1:0]   sum;
    logic signed [CMD_W-1:0]   cmd;
    logic signed [CMD_W-1:0]   max_pos;
    logic signed [CMD_W-1:0]   max_neg;
    logic signed [DRIVE_W-1:0] bow_next;

    always_comb
    begin
        sum     = 38'(prod.pterm) + 38'(prod.dterm) + 38'(prod.iterm);
        // Arithmetic shift floors toward minus infinity.
        cmd     = 26'(sum >>> FRAC_BITS);
        max_pos = 26'(DRIVE_MAX);
        max_neg = -max_pos;
        if (cmd > max_pos)
            bow_next = 8'(max_pos);
        else if (cmd < max_neg)
            bow_next = 8'(max_neg);
        else
            bow_next = 8'(cmd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= prod_valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance && prod_valid)
        begin
            bow_reg    <= bow_next;
            stern_reg  <= -bow_next;
            stable_reg <= prod.stable;
        end
    end

    assign bow_drive      = bow_reg;
    assign stern_drive    = stern_reg;
    assign heading_stable = stable_reg;
    assign out_valid      = out_valid_reg;

    a_bow_in_range: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid |-> (bow_drive <= 8'sd100 && bow_drive >= -8'sd100)
    ) else $error("bow drive outside the percent range");

endmodule

### rtl/heading_pid_thruster_drive.sv
// Top level of the heading PID regulator that drives the bow and stern thrusters.
//
// Input channel: each transaction is either a target update (kind set), which
// stores a new wanted heading and clears the integral and previous error, or a
// control tick carrying the measured heading and the uptime in milliseconds.
// Only ticks produce an output transaction: bow and stern drive in percent
// (stern is the negative of bow) and a one-tick heading_stable pulse.
// Configuration: a separate write channel that is always ready; a write to an
// index beyond the register list is dropped. Write it only while idle.
// A tick accepted at the input passes through the input register, the tracking
// stage, the product stage and the output register, in that order.
// Throughput: one transaction per cycle when the receiver keeps up. The
// tracking stage closes the state loop (error wrap, integral clamp and the
// proportional product). Each stage has its own valid bit, so empty stages
// keep filling while the receiver stalls; in_ready drops only once every
// stage holds an item. Reset restores register defaults, the first-pass state
// and clears all valid bits; no transaction is in flight after reset.
module heading_pid_thruster_drive
    import hpid_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,

    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic                      kind,
    input  logic [HEAD_W-1:0]         measured_heading,
    input  logic [HEAD_W-1:0]         target_heading,
    input  logic [31:0]               uptime_ms,

    output logic                      out_valid,
    input  logic                      out_ready,
    output logic signed [DRIVE_W-1:0] bow_drive,
    output logic signed [DRIVE_W-1:0] stern_drive,
    output logic                      heading_stable,

    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]     cfg_data
);

    cfg_t   cfg;
    item_t  item_reg;
    logic   item_valid_reg;
    track_t track;
    logic   track_valid;
    prod_t  prod;
    logic   prod_valid;

    // Stage enables: a stage may load when it is empty or its content moves on.
    logic   out_advance;
    logic   prod_advance;
    logic   track_advance;
    logic   item_advance;

    assign out_advance   = !out_valid || out_ready;
    assign prod_advance  = !prod_valid || out_advance;
    assign track_advance = !track_valid || prod_advance;
    assign item_advance  = !item_valid_reg || track_advance;

    assign in_ready  = item_advance;
    assign cfg_ready = 1'b1;

    hpid_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Input register: holds the accepted transaction until the tracking stage takes it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_valid_reg <= 1'b0;
        else if (item_advance)
            item_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (item_advance && in_valid)
        begin
            item_reg.kind     <= item_kind_t'(kind);
            item_reg.measured <= measured_heading;
            item_reg.target   <= target_heading;
            item_reg.uptime   <= uptime_ms;
        end
    end

    hpid_track u_track (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .item         (item_reg),
        .item_valid   (item_valid_reg),
        .advance      (track_advance),
        .result       (track),
        .result_valid (track_valid)
    );

    hpid_mult u_mult (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .track       (track),
        .track_valid (track_valid),
        .advance     (prod_advance),
        .prod        (prod),
        .prod_valid  (prod_valid)
    );

    hpid_drive u_drive (
        .clk            (clk),
        .rst_n          (rst_n),
        .prod           (prod),
        .prod_valid     (prod_valid),
        .advance        (out_advance),
        .bow_drive      (bow_drive),
        .stern_drive    (stern_drive),
        .heading_stable (heading_stable),
        .out_valid      (out_valid)
    );

    // Backpressure reaches the input only when the whole pipeline is occupied.
    a_ready_only_when_full: assert property (
        @(posedge clk) disable iff (!rst_n)
        !in_ready |-> (item_valid_reg && track_valid && prod_valid && out_valid && !out_ready)
    ) else $error("input stalled while a stage was free");

    // A stalled result must not be overwritten by a later one.
    a_result_held_on_stall: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(bow_drive)
                                       && $stable(heading_stable))
    ) else $error("stalled result changed");

endmodule
